// ----- rtl/sme_pkg.sv -----
// Package for the stack machine execute core: opcodes, error codes, defaults.
package sme_pkg;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int CODE_ADDR_BITS_DEF = 16;

  localparam logic [4:0] OP_PUSH  = 5'd0;
  localparam logic [4:0] OP_POP   = 5'd1;
  localparam logic [4:0] OP_LABEL = 5'd2;
  localparam logic [4:0] OP_JMP   = 5'd3;
  localparam logic [4:0] OP_JL    = 5'd4;
  localparam logic [4:0] OP_JG    = 5'd5;
  localparam logic [4:0] OP_JE    = 5'd6;
  localparam logic [4:0] OP_JNE   = 5'd7;
  localparam logic [4:0] OP_ADD   = 5'd8;
  localparam logic [4:0] OP_SUB   = 5'd9;
  localparam logic [4:0] OP_MUL   = 5'd10;
  localparam logic [4:0] OP_DIV   = 5'd11;
  localparam logic [4:0] OP_STORE = 5'd12;
  localparam logic [4:0] OP_LOAD  = 5'd13;
  localparam logic [4:0] OP_CALL  = 5'd14;
  localparam logic [4:0] OP_RET   = 5'd15;
  localparam logic [4:0] OP_STACK = 5'd16;
  localparam logic [4:0] OP_PRINT = 5'd17;
  localparam logic [4:0] OP_HLT   = 5'd18;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_INDEX = 3'd3;
  localparam logic [2:0] ERR_DIV0  = 3'd4;
endpackage

// ----- rtl/stack_machine_execute_core.sv -----
// Top level of the stack machine execute core.
// Usage: one decoded instruction enters per input word (in_kind, in_operand_a,
// in_operand_b, in_next_address) when in_valid is high and in_stall is low.
// One result word per instruction leaves on the out_ channel (out_valid,
// out_stall from the receiver). The data stack sits in a synchronous RAM with
// one write and one read port; the core reads up to two entries, one per cycle,
// then computes and writes back. After accept the core steps through read top,
// read second, execute/write and load result; div adds a shift-subtract loop
// before the load. One instruction is in work at a time and in_stall drops
// the cycle after the result loads, so a new word is taken only after the
// previous word's result has loaded. The result sits in an output register;
// while the receiver stalls, the next instruction is accepted and executed,
// and waits for the register to free.
// Reset clears depth, last popped value, halt flag and all handshake state;
// the stack RAM is not cleared and needs no clearing pass.
// After hlt every instruction is answered with halted set and no effect.
module stack_machine_execute_core #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int CODE_ADDR_BITS = sme_pkg::CODE_ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_kind,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  input  logic [15:0]        in_next_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_jump_taken,
  output logic [15:0]        out_jump_target,
  output logic               out_print_valid,
  output logic signed [31:0] out_print_value,
  output logic               out_halted,
  output logic signed [31:0] out_last_popped,
  output logic [2:0]         out_error_code
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXE  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [31:0] mem [STACK_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  logic [2:0]  state_r, state_nxt;
  logic [DW-1:0] depth_r;
  logic [31:0] popped_r;
  logic        halt_r;
  logic [4:0]  kind_r;
  logic [31:0] a_r, b_r;
  logic [15:0] nxt_r;
  logic [31:0] x_r;
  logic        ovalid_r;
  logic        jt_r, pv_r;
  logic [15:0] jtg_r;
  logic [31:0] pval_r;
  logic [2:0]  err_r;
  // divider
  logic [31:0] q_r, rem_r, dvs_r;
  logic [5:0]  dcnt_r;
  logic        qneg_r;
  logic        div_go;

  // index resolution against live depth
  function automatic logic [DW:0] resolve(input logic [31:0] raw, input logic [DW-1:0] d);
    logic signed [33:0] i;
    i = {{2{raw[31]}}, raw};
    if (raw[31]) i = i + 34'($unsigned(d));
    if (i < 0 || i >= 34'($unsigned(d))) resolve = {1'b1, {DW{1'b0}}};
    else resolve = {1'b0, i[DW-1:0]};
  endfunction

  logic [DW:0] ra, rb;
  assign ra = resolve(a_r, depth_r);
  assign rb = resolve(b_r, depth_r);

  logic [15:0] cmask;
  assign cmask = (CODE_ADDR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << CODE_ADDR_BITS) - 32'd1);

  logic need2, need1;
  assign need2 = (kind_r >= sme_pkg::OP_JL && kind_r <= sme_pkg::OP_DIV);
  assign need1 = need2 || kind_r == sme_pkg::OP_POP || kind_r == sme_pkg::OP_RET ||
                 kind_r == sme_pkg::OP_PRINT;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

  logic [32:0] dtrial;
  assign dtrial = {rem_r, q_r[31]} - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    rd_addr = AW'(depth_r - DW'(1));
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD1;
      S_RD1: begin
        rd_addr = AW'(depth_r - DW'(1));
        if (kind_r == sme_pkg::OP_LOAD) rd_addr = ra[AW-1:0];
        if (kind_r == sme_pkg::OP_STORE) rd_addr = rb[AW-1:0];
        state_nxt = S_RD2;
      end
      S_RD2: begin
        rd_addr = AW'(depth_r - DW'(2));
        state_nxt = S_EXE;
      end
      S_EXE: state_nxt = div_go ? S_DIV : S_DONE;
      S_DIV: if (dcnt_r == 6'd0) state_nxt = S_DONE;
      S_DONE: if (!ovalid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [31:0] res;
  logic        do_wr;
  logic [AW-1:0] waddr;
  logic [DW-1:0] ndepth;
  logic        njt, npv, nhalt, setpop;
  logic [15:0] njtg;
  logic [2:0]  nerr;
  logic [63:0] prod;
  assign prod = x_r * rd_data_r;

  // execute decode, in S_EXE: x_r = top (or source), rd_data_r = second
  always_comb begin
    do_wr = 1'b0; waddr = AW'(depth_r); res = 32'd0; ndepth = depth_r;
    njt = 1'b0; njtg = 16'd0; npv = 1'b0; nerr = sme_pkg::ERR_OK;
    nhalt = halt_r; setpop = 1'b0;
    if (!halt_r) begin
      if (need2 && depth_r < DW'(2)) nerr = sme_pkg::ERR_UNDER;
      else if (need1 && depth_r == DW'(0)) nerr = sme_pkg::ERR_UNDER;
      else begin
        case (kind_r)
          sme_pkg::OP_PUSH:
            if (depth_r == FULL) nerr = sme_pkg::ERR_OVER;
            else begin do_wr = 1'b1; res = a_r; ndepth = depth_r + DW'(1); end
          sme_pkg::OP_POP: begin setpop = 1'b1; ndepth = depth_r - DW'(1); end
          sme_pkg::OP_JMP: begin njt = 1'b1; njtg = a_r[15:0] & cmask; end
          sme_pkg::OP_JL, sme_pkg::OP_JG, sme_pkg::OP_JE, sme_pkg::OP_JNE: begin
            ndepth = depth_r - DW'(2);
            case (kind_r)
              sme_pkg::OP_JL: njt = $signed(x_r) < $signed(rd_data_r);
              sme_pkg::OP_JG: njt = $signed(x_r) > $signed(rd_data_r);
              sme_pkg::OP_JE: njt = x_r == rd_data_r;
              default:        njt = x_r != rd_data_r;
            endcase
            if (njt) njtg = a_r[15:0] & cmask;
          end
          sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL: begin
            do_wr = 1'b1; waddr = AW'(depth_r - DW'(2)); ndepth = depth_r - DW'(1);
            res = (kind_r == sme_pkg::OP_ADD) ? x_r + rd_data_r :
                  (kind_r == sme_pkg::OP_SUB) ? x_r - rd_data_r : prod[31:0];
          end
          sme_pkg::OP_DIV: if (rd_data_r == 32'd0) nerr = sme_pkg::ERR_DIV0;
          sme_pkg::OP_STORE:
            if (ra[DW] || rb[DW]) nerr = sme_pkg::ERR_INDEX;
            else begin do_wr = 1'b1; waddr = ra[AW-1:0]; res = x_r; end
          sme_pkg::OP_LOAD:
            if (depth_r == FULL) nerr = sme_pkg::ERR_OVER;
            else if (ra[DW]) nerr = sme_pkg::ERR_INDEX;
            else begin do_wr = 1'b1; res = x_r; ndepth = depth_r + DW'(1); end
          sme_pkg::OP_CALL:
            if (depth_r == FULL) nerr = sme_pkg::ERR_OVER;
            else begin
              do_wr = 1'b1; res = {16'd0, nxt_r}; ndepth = depth_r + DW'(1);
              njt = 1'b1; njtg = a_r[15:0] & cmask;
            end
          sme_pkg::OP_RET: begin
            njt = 1'b1; njtg = x_r[15:0] & cmask; ndepth = depth_r - DW'(1);
          end
          sme_pkg::OP_STACK:
            if (depth_r == FULL) nerr = sme_pkg::ERR_OVER;
            else begin do_wr = 1'b1; res = 32'(depth_r); ndepth = depth_r + DW'(1); end
          sme_pkg::OP_PRINT: npv = 1'b1;
          sme_pkg::OP_HLT: nhalt = 1'b1;
          default: ;
        endcase
      end
    end
  end

  assign div_go = state_r == S_EXE && !halt_r && kind_r == sme_pkg::OP_DIV &&
                  depth_r >= DW'(2) && rd_data_r != 32'd0;

  always_comb begin
    wr_en = 1'b0; wr_addr = waddr; wr_data = res;
    if (state_r == S_EXE && !div_go) wr_en = do_wr;
    if (state_r == S_DIV && dcnt_r == 6'd0) begin
      wr_en = 1'b1; wr_addr = AW'(depth_r - DW'(2));
      wr_data = qneg_r ? -q_r : q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; depth_r <= '0; popped_r <= '0; halt_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!ovalid_r || !out_stall)) ovalid_r <= 1'b1;
      else if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (state_r == S_EXE && !div_go) begin
        depth_r <= ndepth; halt_r <= nhalt;
        if (setpop) popped_r <= x_r;
      end
      if (state_r == S_DIV && dcnt_r == 6'd0) depth_r <= depth_r - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      kind_r <= in_kind; a_r <= in_operand_a; b_r <= in_operand_b;
      nxt_r <= in_next_address;
    end
    if (state_r == S_RD2) x_r <= rd_data_r;
    if (state_r == S_EXE) begin
      jt_r <= njt; jtg_r <= njtg; pv_r <= npv;
      pval_r <= npv ? x_r : 32'd0; err_r <= nerr;
    end
    if (div_go) begin
      dcnt_r <= 6'd32;
      qneg_r <= x_r[31] ^ rd_data_r[31];
      q_r <= x_r[31] ? -x_r : x_r;
      rem_r <= '0;
      dvs_r <= rd_data_r[31] ? -rd_data_r : rd_data_r;
    end
    if (state_r == S_DIV && dcnt_r != 6'd0) begin
      dcnt_r <= dcnt_r - 6'd1;
      if (!dtrial[32]) begin
        rem_r <= dtrial[31:0]; q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], q_r[31]}; q_r <= {q_r[30:0], 1'b0};
      end
    end
    if (state_r == S_DONE && (!ovalid_r || !out_stall)) begin
      out_jump_taken <= jt_r; out_jump_target <= jtg_r;
      out_print_valid <= pv_r; out_print_value <= pval_r;
      out_halted <= halt_r; out_last_popped <= popped_r;
      out_error_code <= err_r;
    end
  end
endmodule
